FILE: sv/crc32fc_pkg.sv
// Shared types and constants of the CRC-32 frame checker.
package crc32fc_pkg;

    localparam int unsigned CntW = 10;
    localparam logic [CntW-1:0] CountMax   = 10'd1023;
    localparam logic [CntW-1:0] MaxFrame   = 10'd512;
    localparam logic [CntW-1:0] RfidCmdLen = 10'd5;
    localparam logic [CntW-1:0] DelayDepth = 10'd4;
    localparam logic [CntW-1:0] HdrLen     = 10'd6;
    localparam logic [CntW-1:0] MinLen     = 10'd5;
    localparam logic [CntW-1:0] MinHdrLen  = 10'd10;

    localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
    localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

    localparam logic [7:0] HdrSync0 = 8'hE5;
    localparam logic [7:0] HdrSync1 = 8'h5E;
    localparam logic [7:0] HdrZero  = 8'h00;

    // Header byte offsets.
    localparam logic [2:0] OffSync0 = 3'd0;
    localparam logic [2:0] OffSync1 = 3'd1;
    localparam logic [2:0] OffAddr  = 3'd3;
    localparam logic [2:0] OffType  = 3'd5;

    // Frame type codes, also used as payload kind.
    localparam logic [1:0] FtNone   = 2'd0;
    localparam logic [1:0] FtWeight = 2'd1;
    localparam logic [1:0] FtRfid   = 2'd2;

    // Register indexes on the configuration port.
    localparam logic RegNodeAddr   = 1'b0;
    localparam logic RegLinkEnable = 1'b1;

    typedef enum logic [2:0] {
        ST_NONE,
        ST_WEIGHT_OK,
        ST_RFID_OK,
        ST_CRC_ERR,
        ST_HDR_MISMATCH,
        ST_TOO_SHORT,
        ST_OVERSIZE,
        ST_DISABLED
    } status_t;

    typedef struct packed {
        logic [3:0] node_addr;
        logic       link_enable;
    } cfg_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [1:0] payload_kind;
        logic       frame_done;
        status_t    frame_status;
    } res_t;

    // One byte through the reflected CRC-32.
    function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
        end
        return c;
    endfunction

endpackage

FILE: sv/crc32fc_cfg.sv
// APB-style configuration registers of the CRC-32 frame checker.
module crc32fc_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output crc32fc_pkg::cfg_t   cfg
);

    logic [3:0] addr_reg;
    logic       link_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= 4'd0;
            link_reg <= 1'b0;
        end else if (wr_en) begin
            case (paddr[2])
                crc32fc_pkg::RegNodeAddr:   addr_reg <= pwdata[3:0];
                crc32fc_pkg::RegLinkEnable: link_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            crc32fc_pkg::RegNodeAddr:   prdata = {28'd0, addr_reg};
            crc32fc_pkg::RegLinkEnable: prdata = {31'd0, link_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    assign cfg.node_addr   = addr_reg;
    assign cfg.link_enable = link_reg;

endmodule

FILE: sv/crc32fc_core.sv
// Frame state, CRC, header check and status logic of the CRC-32 frame checker.
module crc32fc_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                acc_en,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  crc32fc_pkg::cfg_t   cfg,
    output crc32fc_pkg::res_t   res
);

    logic [31:0] crc_reg, crc_next;
    logic [9:0]  cnt_reg, cnt_next;
    logic [7:0]  dly_reg [4];
    logic [7:0]  dly_next [4];
    logic        hm_reg, hm_next;
    logic [1:0]  ft_reg, ft_next;

    logic [7:0]  ob;
    logic [7:0]  want;
    logic [9:0]  off;
    logic [9:0]  pay_idx;
    logic [31:0] trl;
    logic        pv;
    logic [7:0]  pb;
    crc32fc_pkg::status_t status;

    assign ob      = dly_reg[0];
    assign off     = cnt_reg - crc32fc_pkg::DelayDepth;
    assign pay_idx = off - crc32fc_pkg::HdrLen;

    always_comb begin
        crc_next = crc_reg;
        hm_next  = hm_reg;
        ft_next  = ft_reg;
        want     = crc32fc_pkg::HdrZero;
        pv       = 1'b0;
        pb       = 8'd0;
        // The byte leaving the delay line can no longer be part of the trailer.
        if (cnt_reg >= crc32fc_pkg::DelayDepth) begin
            crc_next = crc32fc_pkg::crc_step(crc_reg, ob);
            if (off < crc32fc_pkg::HdrLen) begin
                case (off[2:0])
                    crc32fc_pkg::OffSync0: want = crc32fc_pkg::HdrSync0;
                    crc32fc_pkg::OffSync1: want = crc32fc_pkg::HdrSync1;
                    crc32fc_pkg::OffAddr:  want = {4'd0, cfg.node_addr};
                    crc32fc_pkg::OffType:  want = ob;
                    default:               want = crc32fc_pkg::HdrZero;
                endcase
                if (ob != want) begin
                    hm_next = 1'b0;
                end
                if (off[2:0] == crc32fc_pkg::OffType) begin
                    if (ob == {6'd0, crc32fc_pkg::FtWeight} || ob == {6'd0, crc32fc_pkg::FtRfid}) begin
                        ft_next = ob[1:0];
                    end else begin
                        hm_next = 1'b0;
                    end
                end
            end else if (hm_reg && ft_reg != crc32fc_pkg::FtNone) begin
                if (ft_reg == crc32fc_pkg::FtWeight || pay_idx < crc32fc_pkg::RfidCmdLen) begin
                    pv = 1'b1;
                    pb = ob;
                end
            end
        end

        dly_next[0] = dly_reg[1];
        dly_next[1] = dly_reg[2];
        dly_next[2] = dly_reg[3];
        dly_next[3] = in_byte;
        cnt_next = (cnt_reg < crc32fc_pkg::CountMax) ? cnt_reg + 10'd1 : cnt_reg;

        // After the shift the four newest bytes are the big-endian trailer.
        trl = {dly_reg[1], dly_reg[2], dly_reg[3], in_byte};

        status = crc32fc_pkg::ST_NONE;
        if (in_last) begin
            if (cnt_reg >= crc32fc_pkg::MaxFrame) begin
                status = crc32fc_pkg::ST_OVERSIZE;
            end else if (cnt_reg < crc32fc_pkg::MinLen - 10'd1) begin
                status = crc32fc_pkg::ST_TOO_SHORT;
            end else if (!cfg.link_enable) begin
                status = crc32fc_pkg::ST_DISABLED;
            end else if (cnt_reg < crc32fc_pkg::MinHdrLen - 10'd1) begin
                status = crc32fc_pkg::ST_HDR_MISMATCH;
            end else if (~crc_next != trl) begin
                status = crc32fc_pkg::ST_CRC_ERR;
            end else if (!hm_next || ft_next == crc32fc_pkg::FtNone) begin
                status = crc32fc_pkg::ST_HDR_MISMATCH;
            end else if (ft_next == crc32fc_pkg::FtWeight) begin
                status = crc32fc_pkg::ST_WEIGHT_OK;
            end else begin
                status = crc32fc_pkg::ST_RFID_OK;
            end
        end

        res.payload_valid = pv;
        res.payload_byte  = pb;
        res.payload_kind  = hm_next ? ft_next : crc32fc_pkg::FtNone;
        res.frame_done    = in_last;
        res.frame_status  = status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (acc_en && in_last)) begin
            crc_reg <= crc32fc_pkg::CrcInit;
            cnt_reg <= 10'd0;
            hm_reg  <= 1'b1;
            ft_reg  <= crc32fc_pkg::FtNone;
            for (int i = 0; i < 4; i++) begin
                dly_reg[i] <= 8'd0;
            end
        end else if (acc_en) begin
            crc_reg <= crc_next;
            cnt_reg <= cnt_next;
            hm_reg  <= hm_next;
            ft_reg  <= ft_next;
            for (int i = 0; i < 4; i++) begin
                dly_reg[i] <= dly_next[i];
            end
        end
    end

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_en && in_last |=> cnt_reg == 10'd0 && crc_reg == crc32fc_pkg::CrcInit && hm_reg)
        else $error("frame state not cleared after last word");

    a_payload_after_header: assert property (@(posedge aclk) disable iff (!aresetn)
        pv |-> hm_reg && cnt_reg >= crc32fc_pkg::MinHdrLen)
        else $error("payload emitted before a matching header");

    a_type_only_known: assert property (@(posedge aclk) disable iff (!aresetn)
        ft_reg != crc32fc_pkg::FtNone |-> cnt_reg >= crc32fc_pkg::MinHdrLen)
        else $error("frame type set before the type byte");

    a_status_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        status != crc32fc_pkg::ST_NONE |-> in_last)
        else $error("status reported on a word that is not last");
`endif

endmodule

FILE: sv/crc32fc_out.sv
// Result register of the CRC-32 frame checker.
module crc32fc_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  crc32fc_pkg::res_t   res,
    output logic                m_valid,
    input  logic                m_ready,
    output crc32fc_pkg::res_t   m_res
);

    logic              valid_reg, valid_next;
    crc32fc_pkg::res_t res_reg;
    logic              load;

    // A new word loads while the held result leaves in the same cycle.
    assign s_ready = !valid_reg || m_ready;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

FILE: sv/crc32_frame_checker_top.sv
// Top level of the CRC-32 frame checker.
//
//  Channel  Direction  Payload                                        Handshake
//  s_       in         in_byte, in_last                                s_valid/s_ready
//  m_       out        payload_valid/byte/kind, frame_done/status      m_valid/m_ready
//  APB      in/out     node_addr (0x0), link_enable (0x4)              psel/penable
//
// One word per cycle while s_ready is high; results follow in the next cycle.
// The CRC byte step, header check and status compare sit between the frame state
// and the result register.
// Reset is synchronous and active low; it clears frame state, config and m_valid.
// s_ready stays high while the result register is empty or being drained.
module crc32_frame_checker_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_payload_valid,
    output logic [7:0]  m_payload_byte,
    output logic [1:0]  m_payload_kind,
    output logic        m_frame_done,
    output logic [2:0]  m_frame_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    crc32fc_pkg::cfg_t cfg;
    crc32fc_pkg::res_t res;
    crc32fc_pkg::res_t m_res;
    logic              acc_en;

    assign acc_en = s_valid && s_ready;

    crc32fc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crc32fc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .acc_en  (acc_en),
        .in_byte (s_in_byte),
        .in_last (s_in_last),
        .cfg     (cfg),
        .res     (res)
    );

    crc32fc_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .res     (res),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_payload_valid = m_res.payload_valid;
    assign m_payload_byte  = m_res.payload_byte;
    assign m_payload_kind  = m_res.payload_kind;
    assign m_frame_done    = m_res.frame_done;
    assign m_frame_status  = m_res.frame_status;

endmodule
